// ===== hw/rtl/bps_pkg.sv =====
// Shared constants and types for the block pattern search.
package bps_pkg;

	localparam int MAX_PAT = 16;
	localparam int LEN_W = $clog2(MAX_PAT + 1);
	localparam int IDX_W = $clog2(MAX_PAT);
	localparam int OFS_W = 48;
	localparam int OIB_W = 20;
	localparam int SHIFT_W = 5;
	localparam int MAX_SHIFT = 20;
	localparam int SHIFT_RESET = 9;
	localparam int CFG_DATA_W = 64;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_OFFSET   = 3'd0,
		REG_END_OFFSET     = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_PATTERN_LOW    = 3'd3,
		REG_PATTERN_HIGH   = 3'd4,
		REG_BLOCK_SHIFT    = 3'd5
	} reg_idx_t;

	typedef logic [MAX_PAT-1:0][7:0] bytes_t;

	// Configuration as seen by the datapath, length and shift already clamped.
	typedef struct packed {
		logic [OFS_W-1:0]   start_offset;
		logic [OFS_W-1:0]   end_offset;
		logic [LEN_W-1:0]   pat_len;
		bytes_t             pattern;
		logic [SHIFT_W-1:0] block_shift;
	} cfg_t;

	// Contents of the input stage: window including the current byte.
	typedef struct packed {
		bytes_t           win;
		logic [LEN_W-1:0] cnt;
		logic [OFS_W-1:0] cur;
		logic             first;
	} s1_t;

endpackage

// ===== hw/rtl/bps_cfg.sv =====
// Configuration registers of the block pattern search.
module bps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bps_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0] wr_data,
	output bps_pkg::cfg_t                  cfg
);
	import bps_pkg::*;

	logic [OFS_W-1:0]   start_q;
	logic [OFS_W-1:0]   end_q;
	logic [LEN_W-1:0]   len_q;
	logic [63:0]        pat_lo_q;
	logic [63:0]        pat_hi_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [4:0]         wr_len;
	logic [4:0]         wr_shift;
	logic [LEN_W-1:0]   len_clamped;
	logic [SHIFT_W-1:0] shift_clamped;

	always_comb begin
		wr_len = wr_data[4:0];
		wr_shift = wr_data[4:0];
		if (wr_len == 5'd0) begin
			len_clamped = LEN_W'(1);
		end else if (32'(wr_len) > MAX_PAT) begin
			len_clamped = LEN_W'(MAX_PAT);
		end else begin
			len_clamped = LEN_W'(wr_len);
		end
		if (32'(wr_shift) > MAX_SHIFT) begin
			shift_clamped = SHIFT_W'(MAX_SHIFT);
		end else begin
			shift_clamped = SHIFT_W'(wr_shift);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			end_q    <= '0;
			len_q    <= LEN_W'(1);
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			shift_q  <= SHIFT_W'(SHIFT_RESET);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_START_OFFSET:   start_q  <= wr_data[OFS_W-1:0];
				REG_END_OFFSET:     end_q    <= wr_data[OFS_W-1:0];
				REG_PATTERN_LENGTH: len_q    <= len_clamped;
				REG_PATTERN_LOW:    pat_lo_q <= wr_data;
				REG_PATTERN_HIGH:   pat_hi_q <= wr_data;
				REG_BLOCK_SHIFT:    shift_q  <= shift_clamped;
				default:            ;
			endcase
		end
	end

	always_comb begin
		cfg.start_offset = start_q;
		cfg.end_offset   = end_q;
		cfg.pat_len      = len_q;
		cfg.pattern      = {pat_hi_q, pat_lo_q};
		cfg.block_shift  = shift_q;
	end

endmodule

// ===== hw/rtl/bps_window.sv =====
// Input stage: byte window, fill count and stream position.
module bps_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bps_pkg::cfg_t        cfg,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic                 advance,
	output logic                 valid_s1,
	output bps_pkg::s1_t         s1
);
	import bps_pkg::*;

	bytes_t           win_s1;
	logic [LEN_W-1:0] cnt_s1;
	logic [OFS_W-1:0] cur_s1;
	logic             first_s1;
	logic [OFS_W-1:0] pos_q;
	logic [OFS_W-1:0] cur;
	logic [LEN_W-1:0] cnt_next;

	always_comb begin
		cur = first_byte ? cfg.start_offset : pos_q;
		if (first_byte) begin
			cnt_next = LEN_W'(1);
		end else if (cnt_s1 == LEN_W'(MAX_PAT)) begin
			cnt_next = cnt_s1;
		end else begin
			cnt_next = cnt_s1 + LEN_W'(1);
		end
	end

	// Stale bytes left in the window after a restart are never compared,
	// since the fill count gates the match.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < MAX_PAT - 1; j++) begin
				win_s1[j] <= win_s1[j+1];
			end
			win_s1[MAX_PAT-1] <= data_byte;
			cur_s1 <= cur;
			first_s1 <= first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
			pos_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				cnt_s1   <= cnt_next;
				pos_q    <= cur + OFS_W'(1);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		s1.win   = win_s1;
		s1.cnt   = cnt_s1;
		s1.cur   = cur_s1;
		s1.first = first_s1;
	end

endmodule

// ===== hw/rtl/bps_match.sv =====
// Window compare, range checks, match bookkeeping and the result register.
module bps_match (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bps_pkg::cfg_t           cfg,
	input  logic                    valid_s1,
	input  bps_pkg::s1_t            s1,
	input  logic                    out_stall,
	output logic                    advance,
	output logic                    out_valid,
	output logic [bps_pkg::OFS_W-1:0] block_offset,
	output logic [bps_pkg::OIB_W-1:0] offset_in_block,
	output logic                    new_block
);
	import bps_pkg::*;

	logic [OFS_W-1:0]              earliest_q;
	logic [OFS_W-1:0]              last_block_q;
	logic                          block_seen_q;
	logic                          out_valid_q;
	logic [OFS_W-1:0]              block_offset_q;
	logic [OIB_W-1:0]              offset_in_block_q;
	logic                          new_block_q;

	logic [MAX_PAT-1:0][LEN_W:0]   lane_sum;
	logic [MAX_PAT-1:0][IDX_W-1:0] lane_idx;
	logic [MAX_PAT-1:0]            lane_ok;
	logic [OFS_W:0]                end_excl;
	logic [OFS_W:0]                len_w;
	logic [OFS_W:0]                start_w;
	logic [OFS_W-1:0]              start;
	logic [OFS_W-1:0]              earliest_eff;
	logic                          seen_eff;
	logic                          range_ok;
	logic                          start_ok;
	logic                          hit;
	logic [OFS_W-1:0]              blk_mask;
	logic [OFS_W-1:0]              blk;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);

	always_comb begin
		// Window lane j holds pattern byte j + len - MAX_PAT when that is not negative.
		for (int j = 0; j < MAX_PAT; j++) begin
			lane_sum[j] = (LEN_W+1)'(j) + (LEN_W+1)'(cfg.pat_len);
			lane_idx[j] = IDX_W'(lane_sum[j] - (LEN_W+1)'(MAX_PAT));
			lane_ok[j] = (lane_sum[j] < (LEN_W+1)'(MAX_PAT)) ||
				(s1.win[j] == cfg.pattern[lane_idx[j]]);
		end

		end_excl = {1'b0, s1.cur} + (OFS_W+1)'(1);
		len_w = (OFS_W+1)'(cfg.pat_len);
		start_w = end_excl - len_w;
		start = start_w[OFS_W-1:0];
		earliest_eff = s1.first ? cfg.start_offset : earliest_q;
		seen_eff = !s1.first && block_seen_q;

		range_ok = (s1.cnt >= cfg.pat_len) && (end_excl >= len_w) &&
			(end_excl <= {1'b0, cfg.end_offset});
		start_ok = (start >= earliest_eff) && (start >= cfg.start_offset);
		hit = range_ok && start_ok && (&lane_ok);

		blk_mask = {OFS_W{1'b1}} << cfg.block_shift;
		blk = start & blk_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earliest_q   <= '0;
			last_block_q <= '0;
			block_seen_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= hit;
				if (s1.first) begin
					earliest_q   <= cfg.start_offset;
					block_seen_q <= 1'b0;
				end
				if (hit) begin
					// The next match may start right after this one ends.
					earliest_q   <= end_excl[OFS_W-1:0];
					last_block_q <= blk;
					block_seen_q <= 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			block_offset_q    <= blk;
			offset_in_block_q <= start[OIB_W-1:0] & ~blk_mask[OIB_W-1:0];
			new_block_q       <= !seen_eff || (blk != last_block_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign block_offset    = block_offset_q;
	assign offset_in_block = offset_in_block_q;
	assign new_block       = new_block_q;

endmodule

// ===== hw/rtl/block_pattern_search.sv =====
// Top level of the block pattern search: byte stream in, match offsets out.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  data_byte, first_byte
//   out      from block out_valid / out_stall block_offset, offset_in_block, new_block
//   config   to block   wr_en                wr_index, wr_data
//
// One byte is taken per cycle while in_stall is low; the last byte of a match waits in the input
// register until the result register is free, and the match then leaves from the result register.
// The byte passes through the input register, then the parallel window compare and the
// offset checks, which are combinational, fill the result register.
// Reset clears the position, fill count, match history and both valid flags.
// A held result stalls the input stage only when that stage also holds a byte.
module block_pattern_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bps_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           first_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bps_pkg::OFS_W-1:0]      block_offset,
	output logic [bps_pkg::OIB_W-1:0]      offset_in_block,
	output logic                           new_block
);
	import bps_pkg::*;

	cfg_t cfg;
	s1_t  s1;
	logic valid_s1;
	logic advance;
	logic accept;

	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	bps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bps_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.s1         (s1)
	);

	bps_match u_match (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.valid_s1        (valid_s1),
		.s1              (s1),
		.out_stall       (out_stall),
		.advance         (advance),
		.out_valid       (out_valid),
		.block_offset    (block_offset),
		.offset_in_block (offset_in_block),
		.new_block       (new_block)
	);

	// An accepted request always lands in the input stage.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted byte did not reach the input stage");

	// A byte that cannot move on keeps its position.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(s1.cur))
		else $error("stalled input stage lost or changed its byte");

	// A taken result with nothing processed behind it leaves the output empty.
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !advance |=> !out_valid)
		else $error("result repeated after it was taken");

endmodule
